/* src/skt_pkg.sv */
// Shared types and codes for the sorted key table.
`default_nettype none

package skt_pkg;

    // Fixed field widths
    localparam int unsigned KEY_W = 16;
    localparam int unsigned PIN_W = 8;
    localparam int unsigned OUT_W = 9;
    localparam int unsigned CMD_W = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_DUP     = 3'd1,
        ST_FULL    = 3'd2,
        ST_MISSING = 3'd3,
        ST_RANGE   = 3'd4
    } status_t;

    // Source of the reported position
    typedef enum logic [1:0] {
        POS_LO  = 2'd0,
        POS_MID = 2'd1,
        POS_PIN = 2'd2
    } pos_sel_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic     load;
        logic     search_rd;
        logic     step_low;
        logic     step_high;
        logic     shift_init;
        logic     shift;
        logic     write_key;
        logic     read_issue;
        logic     res_load;
        status_t  res_status;
        pos_sel_t res_pos;
        logic     res_key;
    } dp_ctl_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic nonempty;
        logic key_lt;
        logic key_eq;
        logic shift_more;
        logic full;
        logic pin_ok;
        logic is_lookup;
    } dp_stat_t;

endpackage

`default_nettype wire

/* src/skt_ctrl.sv */
// Controller state machine for the sorted key table.
`default_nettype none

module skt_ctrl
    import skt_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [1:0]   command,
    input  wire dp_stat_t     stat,
    output dp_ctl_t           ctl,
    output logic              busy,
    output logic              done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_COMPARE,
        S_SHIFT,
        S_WRITE_KEY,
        S_READ_ISSUE,
        S_READ_TAKE
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;
    logic   done_reg, done_next;

    // Decode the next step and the datapath commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        done_next  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = command[1] ? S_READ_ISSUE : S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (stat.nonempty)
                begin
                    ctl.search_rd = 1'b1;
                    state_next    = S_COMPARE;
                end
                else if (stat.is_lookup)
                begin
                    ctl.res_load   = 1'b1;
                    ctl.res_status = ST_MISSING;
                    ctl.res_pos    = POS_LO;
                    done_next      = 1'b1;
                    state_next     = S_IDLE;
                end
                else if (stat.full)
                begin
                    ctl.res_load   = 1'b1;
                    ctl.res_status = ST_FULL;
                    ctl.res_pos    = POS_LO;
                    done_next      = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    ctl.shift_init = 1'b1;
                    state_next     = S_SHIFT;
                end
            end
            S_COMPARE:
            begin
                if (stat.key_eq)
                begin
                    ctl.res_load   = 1'b1;
                    ctl.res_status = stat.is_lookup ? ST_OK : ST_DUP;
                    ctl.res_pos    = POS_MID;
                    done_next      = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    ctl.step_low  = stat.key_lt;
                    ctl.step_high = !stat.key_lt;
                    state_next    = S_SEARCH;
                end
            end
            S_SHIFT:
            begin
                ctl.shift = 1'b1;
                if (!stat.shift_more)
                begin
                    state_next = S_WRITE_KEY;
                end
            end
            S_WRITE_KEY:
            begin
                ctl.write_key  = 1'b1;
                ctl.res_load   = 1'b1;
                ctl.res_status = ST_OK;
                ctl.res_pos    = POS_LO;
                done_next      = 1'b1;
                state_next     = S_IDLE;
            end
            S_READ_ISSUE:
            begin
                if (stat.pin_ok)
                begin
                    ctl.read_issue = 1'b1;
                    state_next     = S_READ_TAKE;
                end
                else
                begin
                    ctl.res_load   = 1'b1;
                    ctl.res_status = ST_RANGE;
                    ctl.res_pos    = POS_PIN;
                    done_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_READ_TAKE:
            begin
                ctl.res_load   = 1'b1;
                ctl.res_status = ST_OK;
                ctl.res_pos    = POS_PIN;
                ctl.res_key    = 1'b1;
                done_next      = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        busy_next = (state_next != S_IDLE);
    end

    // Hold state and registered handshake outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

/* src/skt_dp.sv */
// Datapath of the sorted key table: key memory, search bounds, shift pointer, result word.
`default_nettype none

module skt_dp
    import skt_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 256
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire dp_ctl_t          ctl,
    output dp_stat_t              stat,
    input  wire logic [CMD_W-1:0] command,
    input  wire logic [KEY_W-1:0] key,
    input  wire logic [PIN_W-1:0] position_in,
    output logic [2:0]            status,
    output logic [OUT_W-1:0]      position_out,
    output logic [KEY_W-1:0]      key_out,
    output logic [OUT_W-1:0]      entry_count
);

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned PW = (CW > PIN_W) ? CW : PIN_W;

    // Key memory, one write and one registered read port
    logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
    logic [KEY_W-1:0] rdata_reg;
    logic             we;
    logic [AW-1:0]    waddr;
    logic [KEY_W-1:0] wdata;
    logic             re;
    logic [AW-1:0]    raddr;

    // Search and shift registers
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    lo_reg;
    logic [CW-1:0]    hi_reg;
    logic [CW-1:0]    mid_reg;
    logic [CW-1:0]    sh_reg;
    logic [AW-1:0]    waddr_reg;
    logic             wpend_reg;
    logic [KEY_W-1:0] key_reg;
    logic [PIN_W-1:0] pin_reg;
    logic             lookup_reg;

    // Result word
    status_t          status_reg;
    logic [OUT_W-1:0] pos_reg;
    logic [KEY_W-1:0] kout_reg;

    logic [CW:0]      bound_sum;
    logic [CW-1:0]    mid_next;
    logic [CW-1:0]    sh_dec;
    logic [CW-1:0]    mid_inc;

    assign bound_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_next  = bound_sum[CW:1];
    assign sh_dec    = sh_reg - 1'b1;
    assign mid_inc   = mid_reg + 1'b1;

    // Report conditions to the controller
    always_comb
    begin
        stat.nonempty   = (lo_reg < hi_reg);
        stat.key_lt     = (key_reg < rdata_reg);
        stat.key_eq     = (key_reg == rdata_reg);
        stat.shift_more = (sh_reg > lo_reg);
        stat.full       = (count_reg >= CW'(TABLE_DEPTH));
        stat.pin_ok     = (PW'(pin_reg) < PW'(count_reg));
        stat.is_lookup  = lookup_reg;
    end

    // Steer the memory ports
    always_comb
    begin
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        re    = 1'b0;
        raddr = '0;
        if (ctl.search_rd)
        begin
            re    = 1'b1;
            raddr = mid_next[AW-1:0];
        end
        if (ctl.shift)
        begin
            if (wpend_reg)
            begin
                we    = 1'b1;
                waddr = waddr_reg;
                wdata = rdata_reg;
            end
            if (stat.shift_more)
            begin
                re    = 1'b1;
                raddr = sh_dec[AW-1:0];
            end
        end
        if (ctl.write_key)
        begin
            we    = 1'b1;
            waddr = lo_reg[AW-1:0];
            wdata = key_reg;
        end
        if (ctl.read_issue)
        begin
            re    = 1'b1;
            raddr = AW'(pin_reg);
        end
    end

    // Write and read the key memory
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            key_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= key_mem[raddr];
        end
    end

    // Track the entry count and the pending shift write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            wpend_reg <= 1'b0;
        end
        else
        begin
            if (ctl.write_key)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (ctl.shift_init)
            begin
                wpend_reg <= 1'b0;
            end
            else if (ctl.shift)
            begin
                wpend_reg <= stat.shift_more;
            end
        end
    end

    // Advance the search bounds, the shift pointer and the result word
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            lo_reg     <= '0;
            hi_reg     <= count_reg;
            key_reg    <= key;
            pin_reg    <= position_in;
            lookup_reg <= (command == CMD_LOOKUP);
        end
        if (ctl.search_rd)
        begin
            mid_reg <= mid_next;
        end
        if (ctl.step_low)
        begin
            hi_reg <= mid_reg;
        end
        if (ctl.step_high)
        begin
            lo_reg <= mid_inc;
        end
        if (ctl.shift_init)
        begin
            sh_reg <= count_reg;
        end
        else if (ctl.shift && stat.shift_more)
        begin
            sh_reg    <= sh_dec;
            waddr_reg <= sh_reg[AW-1:0];
        end
        if (ctl.res_load)
        begin
            status_reg <= ctl.res_status;
            case (ctl.res_pos)
                POS_LO:  pos_reg <= OUT_W'(lo_reg);
                POS_MID: pos_reg <= OUT_W'(mid_reg);
                POS_PIN: pos_reg <= OUT_W'(pin_reg);
                default: pos_reg <= '0;
            endcase
            kout_reg <= ctl.res_key ? rdata_reg : '0;
        end
    end

    assign status       = status_reg;
    assign position_out = pos_reg;
    assign key_out      = kout_reg;
    assign entry_count  = OUT_W'(count_reg);

endmodule

`default_nettype wire

/* src/sorted_key_table.sv */
// Sorted key table: top level joining the controller and the datapath.
// Lookup: a binary search, one memory read and one compare per probe.
// Insert: the lookup, a shift of the entries at and above the slot, then the key write.
// Read by index: one read, or a range status. Done is registered with the result word.
// One command at a time; the single read port, one read per cycle, sets the pace.
// Reset clears the count and the controller; memory contents are not cleared.
`default_nettype none

module sorted_key_table
    import skt_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 256
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [CMD_W-1:0] command,
    input  wire logic [KEY_W-1:0] key,
    input  wire logic [PIN_W-1:0] position_in,
    output logic                  done,
    output logic [2:0]            status,
    output logic [OUT_W-1:0]      position_out,
    output logic [KEY_W-1:0]      key_out,
    output logic [OUT_W-1:0]      entry_count
);

    dp_ctl_t  ctl;
    dp_stat_t stat;

    skt_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .stat    (stat),
        .ctl     (ctl),
        .busy    (busy),
        .done    (done)
    );

    skt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .stat         (stat),
        .command      (command),
        .key          (key),
        .position_in  (position_in),
        .status       (status),
        .position_out (position_out),
        .key_out      (key_out),
        .entry_count  (entry_count)
    );

endmodule

`default_nettype wire

/* src/skt_checker.sv */
// Port-level checks for the sorted key table, bound to the top level.
`default_nettype none

module skt_checker
    import skt_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             done,
    input wire logic [2:0]       status,
    input wire logic [OUT_W-1:0] position_out,
    input wire logic [OUT_W-1:0] entry_count
);

    // An accepted word keeps the block busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // A result ends the busy period and lasts one cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result strobe outside the end of a command");

    // The count changes only with a successful insert result, by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (entry_count != $past(entry_count)) |->
            (done && status == ST_OK && entry_count == $past(entry_count) + 1'b1))
        else $error("entry count changed without an insert");

    // A duplicate key found on insert lies inside the held entries
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_DUP) |-> (position_out < entry_count))
        else $error("duplicate position beyond the count");

endmodule

bind sorted_key_table skt_checker u_skt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .position_out (position_out),
    .entry_count  (entry_count)
);

`default_nettype wire
